/* rtl/ft_pkg.sv */
package ft_pkg;

	typedef enum logic [2:0] {
		OP_SAMPLE  = 3'd0,
		OP_CONTROL = 3'd1,
		OP_FIVE    = 3'd2,
		OP_HOUR    = 3'd3,
		OP_SECOND  = 3'd4,
		OP_READ    = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		REG_START    = 3'd0,
		REG_END      = 3'd1,
		REG_DURATION = 3'd2,
		REG_MODE     = 3'd3,
		REG_LOCKOUT  = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DONE,
		ST_OUT
	} state_t;

	localparam int unsigned WEIGHT_Q16 = 3277;
	localparam logic signed [15:0] HOT_LIMIT = 16'sd1360;
	localparam logic signed [11:0] MIN_RESET = 12'sd800;
	localparam int unsigned ACC_W = 28;
	localparam int unsigned DIV_STEPS = 26;

	// Controller to datapath commands
	typedef struct packed {
		logic exec;
		logic div_start;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic div_needed;
		logic div_done;
	} stat_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [15:0] raw_temp;
		logic [4:0]         history_index;
		logic               history_daily;
	} in_item_t;

	typedef struct packed {
		logic               appliance_on;
		logic               lockout_active;
		logic signed [11:0] smoothed_temp;
		logic [9:0]         set_point_now;
		logic signed [11:0] hist_min;
		logic signed [11:0] hist_max;
		logic [4:0]         run_hour;
		logic [5:0]         run_day;
	} out_item_t;

endpackage

/* rtl/ft_if.sv */
interface ft_in_if;
	logic valid;
	logic ready;
	ft_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ft_out_if;
	logic valid;
	logic ready;
	ft_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/fermentation_thermostat.sv */
// Fermentation thermostat, event driven.
// Input channel: one request carries an operation code (sample, control,
// five-second tick, hour tick, second tick, history read), a temperature and
// a history slot selector. Each request returns exactly one result on the
// output channel: relay state, lockout flag, smoothed temperature, current set
// point, history min/max (zero unless a read) and the running hour and day.
// Configuration: write cfg_we with cfg_index 0..4 (start point, end point,
// duration in days, cooling mode, lockout seconds) while idle.
// Most requests pass through the execute, finish and output states in turn. A
// five-second tick inside the ramp also runs the 26-step serial restoring
// divider for the set point between the execute and finish states.
// One request is in flight at a time; the next is accepted the cycle after
// the result is taken. While the receiver stalls, the result holds and no
// new request is accepted.
// Reset returns the configuration and control state to defaults at once;
// history slots carry valid bits, so no clearing pass is needed.
module fermentation_thermostat #(
	parameter int HOURS_PER_DAY = 24,
	parameter int MAX_DAYS = 32,
	parameter int AVG_FRAC_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	ft_in_if.sink      in_ch,
	ft_out_if.source   out_ch,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data
);
	import ft_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	ft_datapath #(
		.HOURS_PER_DAY (HOURS_PER_DAY),
		.MAX_DAYS      (MAX_DAYS),
		.AVG_FRAC_BITS (AVG_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_ch.valid && in_ch.ready),
		.in_data   (in_ch.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_ch.data)
	);
endmodule

/* rtl/ft_ctrl.sv */
module ft_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output ft_pkg::cmd_t  cmd,
	input  ft_pkg::stat_t stat
);
	import ft_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_EXEC;
			ST_EXEC: state_nx = stat.div_needed ? ST_DIV : ST_DONE;
			ST_DIV:  if (stat.div_done) state_nx = ST_DONE;
			ST_DONE: state_nx = ST_OUT;
			ST_OUT:  if (out_ready) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EXEC: begin
				cmd.exec = 1'b1;
				cmd.div_start = stat.div_needed;
			end
			ST_DIV:  cmd.div_step = 1'b1;
			ST_DONE: cmd.finish = 1'b1;
			ST_OUT:  out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

/* rtl/ft_datapath.sv */
module ft_datapath #(
	parameter int HOURS_PER_DAY = 24,
	parameter int MAX_DAYS = 32,
	parameter int AVG_FRAC_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  ft_pkg::in_item_t  in_data,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [9:0]        cfg_data,
	input  ft_pkg::cmd_t      cmd,
	output ft_pkg::stat_t     stat,
	output ft_pkg::out_item_t out_data
);
	import ft_pkg::*;

	localparam int HW = (HOURS_PER_DAY > 1) ? $clog2(HOURS_PER_DAY) : 1;
	localparam int DW = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
	localparam int DCW = $clog2(MAX_DAYS + 1);
	localparam int AW = ACC_W;
	localparam int NUMW = 16;

	// Configuration
	logic [9:0] start_q, end_q;
	logic [4:0] dur_q;
	logic       mode_q;
	logic [7:0] lockcfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 10'd288;
			end_q <= 10'd352;
			dur_q <= 5'd20;
			mode_q <= 1'b1;
			lockcfg_q <= 8'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START:    start_q <= cfg_data;
				REG_END:      end_q <= cfg_data;
				REG_DURATION: dur_q <= cfg_data[4:0];
				REG_MODE:     mode_q <= cfg_data[0];
				REG_LOCKOUT:  lockcfg_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// State
	logic signed [AW-1:0] acc_q;
	logic [9:0] target_q;
	logic relay_q;
	logic [7:0] lock_q;
	logic [4:0] hour_q;
	logic [DCW-1:0] day_q;
	in_item_t item_q;
	logic signed [11:0] hmin_q, hmax_q;

	// Stores with valid bits; invalid entries read as reset values
	logic signed [11:0] hmax_mem [HOURS_PER_DAY];
	logic signed [11:0] hmin_mem [HOURS_PER_DAY];
	logic signed [11:0] dmax_mem [MAX_DAYS];
	logic signed [11:0] dmin_mem [MAX_DAYS];
	logic [HOURS_PER_DAY-1:0] hval_q;
	logic [MAX_DAYS-1:0] dval_q;

	// Hour and day stay in 1..limit, so the slot is the count minus one
	logic [HW-1:0] hslot;
	logic [DW-1:0] dslot;
	logic signed [11:0] hmax_cur, hmin_cur, dmax_cur, dmin_cur;
	assign hslot = HW'(hour_q - 5'd1);
	assign dslot = DW'(day_q - DCW'(1));
	assign hmax_cur = hval_q[hslot] ? hmax_mem[hslot] : 12'sd0;
	assign hmin_cur = hval_q[hslot] ? hmin_mem[hslot] : MIN_RESET;
	assign dmax_cur = dval_q[dslot] ? dmax_mem[dslot] : 12'sd0;
	assign dmin_cur = dval_q[dslot] ? dmin_mem[dslot] : MIN_RESET;

	// Smoothed value
	logic signed [AW-AVG_FRAC_BITS-1:0] acc_int;
	logic signed [11:0] smooth;
	assign acc_int = acc_q[AW-1:AVG_FRAC_BITS];
	always_comb begin
		if (acc_int > (AW-AVG_FRAC_BITS)'(2047)) smooth = 12'sd2047;
		else if (acc_int < -(AW-AVG_FRAC_BITS)'(2048)) smooth = -12'sd2048;
		else smooth = acc_int[11:0];
	end

	// Sample update: 43-bit product, floor shift, saturate
	logic signed [AW+1:0] delta;
	logic signed [AW+14:0] prod;
	logic signed [AW+1:0] acc_sum;
	logic signed [AW-1:0] acc_new;
	logic take_sample;
	always_comb begin
		delta = (AW+2)'(signed'(item_q.raw_temp)) * (AW+2)'(2**AVG_FRAC_BITS)
			- (AW+2)'(acc_q);
		prod = (AW+15)'(delta) * (AW+15)'(signed'(17'(WEIGHT_Q16)));
		acc_sum = (AW+2)'(acc_q) + (AW+2)'(prod >>> 16);
		if (acc_sum > (AW+2)'(2**(AW-1)-1)) acc_new = {1'b0, {(AW-1){1'b1}}};
		else if (acc_sum < -(AW+2)'(2**(AW-1))) acc_new = {1'b1, {(AW-1){1'b0}}};
		else acc_new = acc_sum[AW-1:0];
		take_sample = (item_q.raw_temp != 16'sd0) && (item_q.raw_temp < HOT_LIMIT);
	end

	// Control decision
	logic above, want;
	assign above = acc_q > (AW)'($signed({1'b0, target_q})) * (AW)'(2**AVG_FRAC_BITS);
	assign want = (mode_q == above);

	// Ramp numerator and denominator
	logic [NUMW-1:0] num, den;
	assign num = NUMW'((day_q - DCW'(1)) * HOURS_PER_DAY) + NUMW'(hour_q - 5'd1);
	assign den = NUMW'(dur_q * HOURS_PER_DAY);
	assign stat.div_needed = (item_q.operation == OP_FIVE) && (den != '0) && (num < den);

	// Serial restoring divide of |diff|*num by den
	logic signed [10:0] diff;
	logic neg_q;
	logic [25:0] dividend_q;
	logic [NUMW:0] rem_q;
	logic [4:0] dcount_q;
	logic [NUMW:0] rem_sh;
	assign diff = $signed({1'b0, end_q}) - $signed({1'b0, start_q});
	assign rem_sh = {rem_q[NUMW-1:0], dividend_q[25]};
	assign stat.div_done = (dcount_q == 5'(DIV_STEPS));

	logic [10:0] off;
	logic [9:0] target_div;
	assign off = neg_q ? 11'(-dividend_q[10:0]) : dividend_q[10:0];
	assign target_div = 10'(11'(start_q) + off);

	logic [DCW-1:0] day_inc;
	assign day_inc = (day_q < DCW'(MAX_DAYS)) ? day_q + DCW'(1) : day_q;

	always_ff @(posedge clk) begin
		if (in_fire) item_q <= in_data;
		if (cmd.div_start) begin
			neg_q <= diff[10];
			dividend_q <= 26'((diff[10] ? 11'(-diff) : 11'(diff)) * num);
			rem_q <= '0;
			dcount_q <= '0;
		end else if (cmd.div_step && !stat.div_done) begin
			dcount_q <= dcount_q + 5'd1;
			if (rem_sh >= {1'b0, den}) begin
				rem_q <= rem_sh - {1'b0, den};
				dividend_q <= {dividend_q[24:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				dividend_q <= {dividend_q[24:0], 1'b0};
			end
		end
		// History read result
		if (cmd.exec) begin
			hmin_q <= '0;
			hmax_q <= '0;
			if (item_q.operation == OP_READ) begin
				if (item_q.history_daily) begin
					if (32'(item_q.history_index) < MAX_DAYS) begin
						hmin_q <= dval_q[DW'(item_q.history_index)]
							? dmin_mem[DW'(item_q.history_index)] : MIN_RESET;
						hmax_q <= dval_q[DW'(item_q.history_index)]
							? dmax_mem[DW'(item_q.history_index)] : 12'sd0;
					end
				end else if (32'(item_q.history_index) < HOURS_PER_DAY) begin
					hmin_q <= hval_q[HW'(item_q.history_index)]
						? hmin_mem[HW'(item_q.history_index)] : MIN_RESET;
					hmax_q <= hval_q[HW'(item_q.history_index)]
						? hmax_mem[HW'(item_q.history_index)] : 12'sd0;
				end
			end
		end
		// Store updates
		if (cmd.finish && item_q.operation == OP_FIVE) begin
			hmax_mem[hslot] <= (smooth > hmax_cur) ? smooth : hmax_cur;
			hmin_mem[hslot] <= (smooth < hmin_cur) ? smooth : hmin_cur;
		end
		if (cmd.exec && item_q.operation == OP_HOUR) begin
			dmax_mem[dslot] <= (hmax_cur > dmax_cur) ? hmax_cur : dmax_cur;
			dmin_mem[dslot] <= (hmin_cur < dmin_cur) ? hmin_cur : dmin_cur;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= AW'(320 * (2**AVG_FRAC_BITS));
			target_q <= 10'd344;
			relay_q <= 1'b0;
			lock_q <= '0;
			hour_q <= 5'd1;
			day_q <= DCW'(1);
			hval_q <= '0;
			dval_q <= '0;
		end else begin
			if (cmd.exec) begin
				case (item_q.operation)
					OP_SAMPLE: if (take_sample) acc_q <= acc_new;
					OP_CONTROL: if (lock_q == '0 && want != relay_q) begin
						relay_q <= want;
						lock_q <= lockcfg_q;
					end
					OP_HOUR: begin
						dval_q[dslot] <= 1'b1;
						if (hour_q >= 5'(HOURS_PER_DAY)) begin
							hour_q <= 5'd1;
							day_q <= day_inc;
						end else begin
							hour_q <= hour_q + 5'd1;
						end
					end
					OP_SECOND: if (lock_q != '0) lock_q <= lock_q - 8'd1;
					default: ;
				endcase
			end
			if (cmd.finish && item_q.operation == OP_FIVE) begin
				hval_q[hslot] <= 1'b1;
				target_q <= stat.div_needed ? target_div : end_q;
			end
		end
	end

	assign out_data.appliance_on = relay_q;
	assign out_data.lockout_active = (lock_q != '0);
	assign out_data.smoothed_temp = smooth;
	assign out_data.set_point_now = target_q;
	assign out_data.hist_min = hmin_q;
	assign out_data.hist_max = hmax_q;
	assign out_data.run_hour = hour_q;
	assign out_data.run_day = 6'(day_q);
endmodule
